/* src/tmtw_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tmtw_pkg
// Shared types and constants for the text-mode terminal writer: command
// codes, character constants, the request and response payloads, and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package tmtw_pkg;

    localparam int CMD_W       = 2;
    localparam int CHAR_W      = 8;
    localparam int INDEX_W     = 11;
    localparam int ROW_OUT_W   = 5;
    localparam int COL_OUT_W   = 7;
    localparam int CELL_W      = 16;
    localparam int COLOR_W     = 8;

    // Command codes carried in the request's cmd field.
    localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    localparam logic [CHAR_W-1:0]  NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0]  SPACE_CODE   = 8'd32;
    localparam logic [COLOR_W-1:0] LIGHT_GREY   = 8'd7;

    // Register select: the register index is paddr[2].
    localparam logic REG_TEXT_COLOR = 1'b0;

    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [CHAR_W-1:0]  char_code;
        logic [INDEX_W-1:0] cell_index;
    } req_item_t;

    typedef struct packed {
        logic [ROW_OUT_W-1:0] cursor_row;
        logic [COL_OUT_W-1:0] cursor_col;
        logic [CELL_W-1:0]    cell_data;
        logic                 scrolled;
    } rsp_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;          // request accepted this cycle
        logic sweep_start;   // restart the cell counter
        logic fill_grey;     // write a light grey space at the counter
        logic copy_step;     // one step of the scroll copy
        logic fill_color;    // blank one bottom-row cell in the text color
        logic emit_now;      // push the result of the request taken now
        logic emit_read;     // push the result of a cell read
        logic emit_cursor;   // push the cursor after a sweep
        logic emit_scrolled; // with emit_cursor: the step scrolled
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic will_scroll;   // the offered put runs past the bottom row
        logic fill_last;     // counter on the last cell
        logic copy_last;     // counter at the end of the copy
        logic blank_last;    // counter at the end of the bottom-row blank
    } dp_stat_t;

endpackage
`default_nettype wire

/* src/text_mode_terminal_writer_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// text_mode_terminal_writer_core
// Character terminal over a ROWS x COLUMNS text cell memory, with cursor,
// line wrap, newline, scroll, cell read and clear-screen commands.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake              Payload      Direction
//  -------   --------------------   ----------   ---------
//  req       req_valid/req_ready    req_item_t   into core
//  rsp       rsp_valid/rsp_ready    rsp_item_t   out of core
//  apb       psel/penable/pready    pwdata       register writes and reads
//
// A put that stays on the screen and an unused command each finish in the
// cycle they are accepted, so while the response buffer has room a stream
// of them runs at one transaction per cycle. A cell read is answered from
// the ST_READ state, as the cell memory has a registered read port. A put
// that runs past the bottom row holds off new requests while the scroll
// moves one cell per cycle through the memory's single read and write port,
// then blanks the bottom row one cell per cycle. A clear, and the core after
// reset, sweeps the whole memory to light grey spaces with req_ready low;
// register writes are taken during that time. Responses go through a
// two-entry buffer, so one new request is taken while a finished response
// waits on a stalled rsp_ready.
// ----------------------------------------------------------------------------
module text_mode_terminal_writer_core
    import tmtw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Register port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    // Request channel.
    input  wire logic        req_valid,
    output logic             req_ready,
    input  wire req_item_t   req,

    // Response channel.
    output logic             rsp_valid,
    input  wire logic        rsp_ready,
    output rsp_item_t        rsp
);

    logic [COLOR_W-1:0] text_color_reg, text_color_next;
    logic               color_sel;
    dp_cmd_t            dp_cmd;
    dp_stat_t           dp_stat;
    logic               res_push;
    rsp_item_t          res_data;
    logic               out_room;

    // The attribute register sits at byte address 0. A write completes in
    // the access phase; addresses with paddr[2] set ignore writes and read as 0.
    always_comb
    begin
        color_sel       = paddr[2] == REG_TEXT_COLOR;
        text_color_next = text_color_reg;
        if (psel && penable && pwrite && color_sel)
            text_color_next = pwdata[COLOR_W-1:0];
        prdata = color_sel ? 32'(text_color_reg) : '0;
        pready = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            text_color_reg <= LIGHT_GREY;
        else
            text_color_reg <= text_color_next;
    end

    // The controller decides what the datapath does each cycle; the
    // datapath reports where its sweep counter stands and whether the
    // request on offer would scroll.
    tmtw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_cmd   (req.cmd),
        .out_room  (out_room),
        .stat      (dp_stat),
        .req_ready (req_ready),
        .cmd       (dp_cmd)
    );

    tmtw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (dp_cmd),
        .req        (req),
        .text_color (text_color_reg),
        .stat       (dp_stat),
        .res_push   (res_push),
        .res_data   (res_data)
    );

    // Response buffer between the core and the consumer.
    tmtw_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_data),
        .room      (out_room),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
`default_nettype wire

/* src/tmtw_out_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tmtw_out_stage
// Two-entry response buffer: an output register plus a skid entry, so that a
// new request can be taken while a finished response still waits.
// ----------------------------------------------------------------------------
module tmtw_out_stage
    import tmtw_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire rsp_item_t push_data,
    output logic           room,
    output logic           rsp_valid,
    input  wire logic      rsp_ready,
    output rsp_item_t      rsp
);

    logic      out_valid_reg, out_valid_next;
    logic      hold_valid_reg, hold_valid_next;
    rsp_item_t out_data_reg, out_data_next;
    rsp_item_t hold_data_reg, hold_data_next;
    logic      out_free;

    always_comb
    begin
        out_free        = !out_valid_reg || rsp_ready;
        out_valid_next  = out_valid_reg;
        hold_valid_next = hold_valid_reg;
        out_data_next   = out_data_reg;
        hold_data_next  = hold_data_reg;
        if (out_free)
        begin
            if (hold_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = hold_data_reg;
                hold_valid_next = push;
                hold_data_next  = push_data;
            end
            else
            begin
                out_valid_next = push;
                out_data_next  = push_data;
            end
        end
        else if (push)
        begin
            hold_valid_next = 1'b1;
            hold_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        hold_data_reg <= hold_data_next;
    end

    assign room      = !hold_valid_reg;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

endmodule
`default_nettype wire

/* src/tmtw_datapath.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tmtw_datapath
// Cell memory, cursor registers, sweep counter and response assembly.
// ----------------------------------------------------------------------------
module tmtw_datapath
    import tmtw_pkg::*;
#(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire dp_cmd_t            cmd,
    input  wire req_item_t          req,
    input  wire logic [COLOR_W-1:0] text_color,
    output dp_stat_t                stat,
    output logic                    res_push,
    output rsp_item_t               res_data
);

    localparam int CELL_COUNT = ROWS * COLUMNS;
    localparam int COPY_END   = CELL_COUNT - COLUMNS;
    localparam int AW         = $clog2(CELL_COUNT);
    localparam int CNT_W      = $clog2(CELL_COUNT + 1);
    localparam int IDX_W      = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;
    localparam int RW         = $clog2(ROWS);
    localparam int CW         = $clog2(COLUMNS);

    logic [CELL_W-1:0] cells_mem [CELL_COUNT];
    logic [CELL_W-1:0] rd_data_reg;
    logic              rd_ok_reg, rd_ok_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [CW-1:0]     col_reg, col_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    logic              is_put, is_nl, row_last, col_last, line_end;
    logic [IDX_W-1:0]  idx_wide;
    logic              idx_ok;
    logic [CNT_W-1:0]  pos_full, src_full, cnt_m1;
    logic              mem_we, mem_re;
    logic [AW-1:0]     waddr, raddr;
    logic [CELL_W-1:0] wdata;

    // Cursor update for the request taken this cycle.
    always_comb
    begin
        is_put   = req.cmd == CMD_PUT;
        is_nl    = req.char_code == NEWLINE_CODE;
        row_last = row_reg == RW'(ROWS - 1);
        col_last = col_reg == CW'(COLUMNS - 1);
        line_end = is_put && (is_nl || col_last);
        row_next = row_reg;
        col_next = col_reg;
        if (cmd.take)
        begin
            if (is_put)
            begin
                if (line_end)
                begin
                    col_next = '0;
                    if (!row_last)
                        row_next = row_reg + 1'b1;
                end
                else
                    col_next = col_reg + 1'b1;
            end
            else if (req.cmd == CMD_CLEAR)
            begin
                row_next = '0;
                col_next = '0;
            end
        end
    end

    // Memory port selection.
    always_comb
    begin
        idx_wide = IDX_W'(req.cell_index);
        idx_ok   = idx_wide < IDX_W'(CELL_COUNT);
        pos_full = CNT_W'(row_reg) * CNT_W'(COLUMNS) + CNT_W'(col_reg);
        src_full = cnt_reg + CNT_W'(COLUMNS);
        cnt_m1   = cnt_reg - CNT_W'(1);

        mem_we = 1'b0;
        waddr  = pos_full[AW-1:0];
        wdata  = {text_color, req.char_code};
        if (cmd.take && is_put && !is_nl)
            mem_we = 1'b1;
        else if (cmd.fill_grey)
        begin
            mem_we = 1'b1;
            waddr  = cnt_reg[AW-1:0];
            wdata  = {LIGHT_GREY, SPACE_CODE};
        end
        else if (cmd.copy_step)
        begin
            mem_we = cnt_reg != '0;
            waddr  = cnt_m1[AW-1:0];
            wdata  = rd_data_reg;
        end
        else if (cmd.fill_color)
        begin
            mem_we = 1'b1;
            waddr  = cnt_m1[AW-1:0];
            wdata  = {text_color, SPACE_CODE};
        end

        mem_re = 1'b0;
        raddr  = idx_wide[AW-1:0];
        if (cmd.take)
            mem_re = (req.cmd == CMD_READ) && idx_ok;
        else if (cmd.copy_step)
        begin
            mem_re = !stat.copy_last;
            raddr  = src_full[AW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            cells_mem[waddr] <= wdata;
        if (mem_re)
            rd_data_reg <= cells_mem[raddr];
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.sweep_start)
            cnt_next = '0;
        else if (cmd.fill_grey || cmd.copy_step || cmd.fill_color)
            cnt_next = cnt_reg + 1'b1;
        rd_ok_next = cmd.take ? idx_ok : rd_ok_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg   <= '0;
            col_reg   <= '0;
            cnt_reg   <= '0;
            rd_ok_reg <= 1'b0;
        end
        else
        begin
            row_reg   <= row_next;
            col_reg   <= col_next;
            cnt_reg   <= cnt_next;
            rd_ok_reg <= rd_ok_next;
        end
    end

    always_comb
    begin
        stat.will_scroll = line_end && row_last;
        stat.fill_last   = cnt_reg == CNT_W'(CELL_COUNT - 1);
        stat.copy_last   = cnt_reg == CNT_W'(COPY_END);
        stat.blank_last  = cnt_reg == CNT_W'(CELL_COUNT);

        res_push            = cmd.emit_now || cmd.emit_read || cmd.emit_cursor;
        res_data.cursor_row = ROW_OUT_W'(row_next);
        res_data.cursor_col = COL_OUT_W'(col_next);
        res_data.cell_data  = (cmd.emit_read && rd_ok_reg) ? rd_data_reg : '0;
        res_data.scrolled   = cmd.emit_cursor && cmd.emit_scrolled;
    end

endmodule
`default_nettype wire

/* src/tmtw_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tmtw_ctrl
// Sequencer for the terminal writer: takes requests, runs the power-up
// clear, the clear command, the scroll copy and the bottom-row blank.
// ----------------------------------------------------------------------------
module tmtw_ctrl
    import tmtw_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    input  wire logic [CMD_W-1:0] req_cmd,
    input  wire logic             out_room,
    input  wire dp_stat_t         stat,
    output logic                  req_ready,
    output dp_cmd_t               cmd
);

    typedef enum logic [5:0] {
        ST_INIT  = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_READ  = 6'b000100,
        ST_CLEAR = 6'b001000,
        ST_COPY  = 6'b010000,
        ST_BLANK = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_INIT:
            begin
                cmd.fill_grey = 1'b1;
                if (stat.fill_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                req_ready = out_room;
                cmd.take  = req_valid && out_room;
                if (cmd.take)
                begin
                    case (req_cmd)
                        CMD_PUT:
                        begin
                            if (stat.will_scroll)
                            begin
                                cmd.sweep_start = 1'b1;
                                state_next      = ST_COPY;
                            end
                            else
                                cmd.emit_now = 1'b1;
                        end
                        CMD_READ:  state_next = ST_READ;
                        CMD_CLEAR:
                        begin
                            cmd.sweep_start = 1'b1;
                            state_next      = ST_CLEAR;
                        end
                        default:   cmd.emit_now = 1'b1;
                    endcase
                end
            end
            ST_READ:
            begin
                cmd.emit_read = 1'b1;
                state_next    = ST_IDLE;
            end
            ST_CLEAR:
            begin
                cmd.fill_grey = 1'b1;
                if (stat.fill_last)
                begin
                    cmd.emit_cursor = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_COPY:
            begin
                cmd.copy_step = 1'b1;
                if (stat.copy_last)
                    state_next = ST_BLANK;
            end
            ST_BLANK:
            begin
                cmd.fill_color = 1'b1;
                if (stat.blank_last)
                begin
                    cmd.emit_cursor   = 1'b1;
                    cmd.emit_scrolled = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_INIT;
        else
            state_reg <= state_next;
    end

`ifndef SYNTHESIS
    a_read_emits: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take && req_cmd == CMD_READ |=> cmd.emit_read)
        else $error("read request did not produce its response next cycle");

    a_clear_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take && req_cmd == CMD_CLEAR |=> state_reg == ST_CLEAR)
        else $error("clear request did not start the clear sweep");

    a_copy_to_blank: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_COPY && stat.copy_last |=> state_reg == ST_BLANK)
        else $error("scroll copy did not hand over to the bottom-row blank");

    a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.emit_now, cmd.emit_read, cmd.emit_cursor}))
        else $error("more than one response source in one cycle");

    a_no_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_COPY |-> !cmd.emit_cursor && !cmd.emit_now)
        else $error("response pushed in the middle of a scroll");
`endif

endmodule
`default_nettype wire

/* sim/text_mode_terminal_writer_core_test.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// text_mode_terminal_writer_core_test
// Self-checking bench for the text-mode terminal writer. A short table of
// commands checks the reset screen, cell reads in and out of range, the
// unused command, puts, newline and clear. Long random phases follow, each
// at its own text color. A shadow screen in the bench predicts every
// response, and responses are compared field by field in order.
// ----------------------------------------------------------------------------
module text_mode_terminal_writer_core_test;
    import tmtw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = ROWS * COLUMNS;

    // The fourth command code is not used by the core; it only reports the cursor.
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;

    // The register index sits at paddr[2], so register 0 is at byte address 0.
    localparam logic [2:0] TEXT_COLOR_ADDR = {REG_TEXT_COLOR, 2'b00};

    localparam int NUM_PHASES      = 6;
    localparam int ITEMS_PER_PHASE = 317;

    // The receiver holds rsp_ready low for this many cycles once, after
    // HOLD_AFTER_RSP responses, while the sender keeps offering requests.
    localparam int HOLD_AFTER_RSP = 600;
    localparam int HOLD_CYCLES    = 400;

    // ------------------------------------------------------------------------
    // Signals to and from the core.
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        req_valid;
    logic        req_ready;
    req_item_t   req;
    logic        rsp_valid;
    logic        rsp_ready;
    rsp_item_t   rsp;

    text_mode_terminal_writer_core #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // ------------------------------------------------------------------------
    // Shadow copy of the terminal: screen cells, cursor and text color.
    // ------------------------------------------------------------------------
    logic [CELL_W-1:0]  shadow_cells [CELL_COUNT];
    int                 shadow_row;
    int                 shadow_col;
    logic [COLOR_W-1:0] shadow_color;

    // Responses still owed by the core, oldest first.
    rsp_item_t pending_rsp [$];

    int n_errors;
    int n_rsp_seen;
    int n_requests;
    int n_scrolls;
    int n_wraps;
    int n_clears;
    int n_reads;
    int n_reads_oob;

    // Sender burst bookkeeping: requests left in the current burst.
    int burst_left;

    // Directed table: one request per row, with a typed expectation where the
    // answer is obvious and a zero has_want where the shadow screen decides.
    typedef struct {
        req_item_t item;
        bit        has_want;
        rsp_item_t want;
    } stim_row_t;

    stim_row_t directed_rows [$];

    // ------------------------------------------------------------------------
    // Shadow screen helpers.
    // ------------------------------------------------------------------------
    function automatic void blank_screen();
        for (int i = 0; i < CELL_COUNT; i++)
            shadow_cells[i] = {LIGHT_GREY, SPACE_CODE};
    endfunction

    // Moves the cursor to the start of the next line. Running off the bottom
    // shifts every line up by one and blanks the last line in the current
    // text color. Returns 1 when that scroll happened.
    function automatic bit advance_line();
        shadow_col = 0;
        shadow_row++;
        if (shadow_row < ROWS)
            return 1'b0;
        for (int i = 0; i + COLUMNS < CELL_COUNT; i++)
            shadow_cells[i] = shadow_cells[i + COLUMNS];
        for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++)
            shadow_cells[i] = {shadow_color, SPACE_CODE};
        shadow_row = ROWS - 1;
        return 1'b1;
    endfunction

    // Applies one command to the shadow screen and returns the response the
    // core must give for it.
    function automatic rsp_item_t apply_terminal_cmd(req_item_t r);
        rsp_item_t o;
        int        pos;
        o = '0;
        case (r.cmd)
            CMD_PUT:
            begin
                if (r.char_code == NEWLINE_CODE)
                begin
                    // A newline writes no cell but may still scroll.
                    o.scrolled = advance_line();
                end
                else
                begin
                    pos = shadow_row * COLUMNS + shadow_col;
                    shadow_cells[pos] = {shadow_color, r.char_code};
                    shadow_col++;
                    if (shadow_col >= COLUMNS)
                    begin
                        n_wraps++;
                        o.scrolled = advance_line();
                    end
                end
            end
            CMD_READ:
            begin
                n_reads++;
                if (r.cell_index < CELL_COUNT)
                    o.cell_data = shadow_cells[r.cell_index];
                else
                    n_reads_oob++;
            end
            CMD_CLEAR:
            begin
                // Clear always uses light grey, whatever the text color is.
                blank_screen();
                shadow_row = 0;
                shadow_col = 0;
                n_clears++;
            end
            default: ;
        endcase
        o.cursor_row = ROW_OUT_W'(shadow_row);
        o.cursor_col = COL_OUT_W'(shadow_col);
        if (o.scrolled)
            n_scrolls++;
        return o;
    endfunction

    function automatic void add_row(logic [CMD_W-1:0] cmd, logic [CHAR_W-1:0] ch,
                                    logic [INDEX_W-1:0] idx, bit has_want,
                                    int row, int col, logic [CELL_W-1:0] data);
        stim_row_t s;
        s.item.cmd        = cmd;
        s.item.char_code  = ch;
        s.item.cell_index = idx;
        s.has_want        = has_want;
        s.want.cursor_row = ROW_OUT_W'(row);
        s.want.cursor_col = COL_OUT_W'(col);
        s.want.cell_data  = data;
        s.want.scrolled   = 1'b0;
        directed_rows.push_back(s);
    endfunction

    // Random request. Reads favor the part of the screen already written to,
    // clears are rare so that the cursor drifts down and scrolls happen.
    function automatic req_item_t random_request();
        req_item_t r;
        int        pick;
        r.cmd        = CMD_PUT;
        r.char_code  = CHAR_W'($urandom_range(0, 255));
        r.cell_index = INDEX_W'($urandom_range(0, 2047));
        pick = $urandom_range(0, 999);
        if (pick < 2)
        begin
            r.cmd = CMD_CLEAR;
        end
        else if (pick < 22)
        begin
            r.cmd = CMD_NOP;
        end
        else if (pick < 72)
        begin
            r.char_code = NEWLINE_CODE;
        end
        else if (pick < 372)
        begin
            r.cmd = CMD_READ;
            if ($urandom_range(0, 1) == 1)
                r.cell_index = INDEX_W'($urandom_range(0, (shadow_row + 1) * COLUMNS - 1));
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Request side. Requests go out in bursts of random length with random
    // gaps between them; a burst with no gap keeps req_valid high throughout.
    // ------------------------------------------------------------------------
    task automatic send_request(input req_item_t item, input bit has_want,
                                input rsp_item_t want);
        int        gap;
        rsp_item_t predicted;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                req_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (!req_ready);
        // The transaction is taken at this edge; record what it must produce.
        predicted = apply_terminal_cmd(item);
        pending_rsp.push_back(has_want ? want : predicted);
        n_requests++;
    endtask

    // Stops offering requests and waits until every response has arrived.
    // Every command gives a response, so after that the core is sure to be
    // idle before a register write.
    task automatic drain();
        @(negedge clk);
        req_valid <= 1'b0;
        burst_left = 0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Writes the text color register and reads it back.
    task automatic set_text_color(input logic [COLOR_W-1:0] color);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TEXT_COLOR_ADDR;
        pwdata  <= {24'd0, color};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        shadow_color = color;
        // Read back: setup with pwrite low, then access.
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata[COLOR_W-1:0] !== color)
        begin
            $display("%0t: text_color readback expected %02h, got %02h",
                     $time, color, prdata[COLOR_W-1:0]);
            n_errors++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Response side.
    // ------------------------------------------------------------------------
    task automatic check_field(input string label, input logic [CELL_W-1:0] want,
                               input logic [CELL_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, label, want, got);
            n_errors++;
        end
    endtask

    always @(posedge clk)
    begin
        rsp_item_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            n_rsp_seen++;
            if (pending_rsp.size() == 0)
            begin
                $display("%0t: response with none expected, got %h", $time, rsp);
                n_errors++;
            end
            else
            begin
                want = pending_rsp.pop_front();
                check_field("cursor_row", CELL_W'(want.cursor_row), CELL_W'(rsp.cursor_row));
                check_field("cursor_col", CELL_W'(want.cursor_col), CELL_W'(rsp.cursor_col));
                check_field("cell_data", want.cell_data, rsp.cell_data);
                check_field("scrolled", CELL_W'(want.scrolled), CELL_W'(rsp.scrolled));
            end
        end
    end

    // The receiver switches between stall patterns of random length: always
    // ready, half ready, mostly ready and mostly stalled. Once in the run it
    // holds off for a long stretch so that the response buffer fills and the
    // core has to stall its request side.
    initial
    begin
        int mode;
        int mode_left;
        int hold_left;
        bit hold_done;
        mode      = 0;
        mode_left = 0;
        hold_left = 0;
        hold_done = 1'b0;
        rsp_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!hold_done && n_rsp_seen >= HOLD_AFTER_RSP)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 3);
                    mode_left = $urandom_range(16, 128);
                end
                mode_left--;
                case (mode)
                    0:       rsp_ready <= 1'b1;
                    1:       rsp_ready <= ($urandom_range(0, 1) == 1);
                    2:       rsp_ready <= ($urandom_range(0, 9) != 0);
                    default: rsp_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Clock and run limit.
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // A scroll or a clear is a full-screen pass over the cell memory. The limit
    // allows for every request of the run causing one, under the slowest
    // receiver, with a wide margin.
    initial
    begin
        #200_000_000;
        $display("%0t: run did not finish in time, %0d responses still owed",
                 $time, pending_rsp.size());
        $display("RESULT: ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial
    begin
        logic [COLOR_W-1:0] phase_colors [NUM_PHASES];
        rsp_item_t          unused_want;

        rst_n       = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        req_valid   = 1'b0;
        req         = '0;
        unused_want = '0;
        n_errors    = 0;
        n_rsp_seen  = 0;
        n_requests  = 0;
        n_scrolls   = 0;
        n_wraps     = 0;
        n_clears    = 0;
        n_reads     = 0;
        n_reads_oob = 0;
        burst_left  = 0;

        blank_screen();
        shadow_row   = 0;
        shadow_col   = 0;
        shadow_color = LIGHT_GREY;

        // Both extremes of the attribute byte, fixed patterns and random ones.
        phase_colors[0] = 8'hFF;
        phase_colors[1] = 8'h00;
        phase_colors[2] = COLOR_W'($urandom_range(0, 255));
        phase_colors[3] = 8'hA5;
        phase_colors[4] = COLOR_W'($urandom_range(0, 255));
        phase_colors[5] = 8'h5A;

        // Directed rows, all at the reset color. The core sweeps its memory
        // after reset with req_ready low; the first request simply waits.
        add_row(CMD_READ,  8'h00, 11'd0,    1, 0, 0, 16'h0720); // reset screen
        add_row(CMD_READ,  8'hFF, 11'd1999, 1, 0, 0, 16'h0720); // last cell
        add_row(CMD_READ,  8'h00, 11'd2000, 1, 0, 0, 16'h0000); // just past the end
        add_row(CMD_READ,  8'h00, 11'd2047, 1, 0, 0, 16'h0000); // all index bits set
        add_row(CMD_NOP,   8'hFF, 11'd2047, 1, 0, 0, 16'h0000); // unused command
        add_row(CMD_PUT,   8'h41, 11'd0,    1, 0, 1, 16'h0000);
        add_row(CMD_PUT,   8'h00, 11'd0,    1, 0, 2, 16'h0000); // lowest char code
        add_row(CMD_PUT,   8'hFF, 11'd2047, 1, 0, 3, 16'h0000); // highest char code
        add_row(CMD_PUT,   NEWLINE_CODE, 11'd0, 1, 1, 0, 16'h0000);
        add_row(CMD_READ,  8'h00, 11'd0,    1, 1, 0, 16'h0741);
        add_row(CMD_READ,  8'h00, 11'd1,    1, 1, 0, 16'h0700);
        add_row(CMD_READ,  8'h00, 11'd2,    1, 1, 0, 16'h07FF);
        add_row(CMD_READ,  8'h00, 11'd3,    1, 1, 0, 16'h0720); // newline wrote nothing
        add_row(CMD_PUT,   8'h7A, 11'd2047, 1, 1, 1, 16'h0000);
        add_row(CMD_READ,  8'h00, 11'd80,   1, 1, 1, 16'h077A);
        add_row(CMD_NOP,   8'h00, 11'd0,    1, 1, 1, 16'h0000);
        add_row(CMD_CLEAR, 8'h00, 11'd0,    1, 0, 0, 16'h0000);
        add_row(CMD_READ,  8'h00, 11'd0,    1, 0, 0, 16'h0720);
        add_row(CMD_READ,  8'h00, 11'd80,   1, 0, 0, 16'h0720);
        add_row(CMD_PUT,   NEWLINE_CODE, 11'd2047, 1, 1, 0, 16'h0000);
        add_row(CMD_READ,  8'h00, 11'd1024, 1, 1, 0, 16'h0720);
        add_row(CMD_CLEAR, 8'hFF, 11'd2047, 1, 0, 0, 16'h0000);
        add_row(CMD_PUT,   8'h80, 11'd0,    0, 0, 0, 16'h0000);
        add_row(CMD_READ,  8'h00, 11'd0,    0, 0, 0, 16'h0000);

        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_request(directed_rows[i].item, directed_rows[i].has_want,
                         directed_rows[i].want);
        drain();

        // Random phases. The color only changes while the core is idle.
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_text_color(phase_colors[p]);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                send_request(random_request(), 1'b0, unused_want);
            drain();
        end

        repeat (20) @(posedge clk);

        $display("Sent %0d requests over %0d text colors: %0d scrolls, %0d line wraps,",
                 n_requests, NUM_PHASES + 1, n_scrolls, n_wraps);
        $display("%0d clears, %0d reads (%0d out of range), %0d errors.",
                 n_clears, n_reads, n_reads_oob, n_errors);
        if (n_errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire
